>>> rtl/pcg32_random_source_assert.svh
// Assertion macros for the PCG32 random source.
// Included by the top level; uses its clk and rst_n.
`ifndef PCG32_RANDOM_SOURCE_ASSERT_SVH
`define PCG32_RANDOM_SOURCE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PCG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pcg_pkg.sv
// Shared types and constants for the PCG32 random source.
// Used by pcg_lcg, pcg_div and pcg32_random_source; depends on nothing.
`default_nettype none

package pcg_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W = $clog2(WORD_W);

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC = 64'd1442695040888963407;
    localparam logic [63:0] PCG_RESET_STATE = PCG_INC * PCG_MULT + PCG_INC;

    typedef enum logic [1:0] {
        OP_RAW     = 2'd0,
        OP_BOUNDED = 2'd1,
        OP_HALF    = 2'd2,
        OP_COIN    = 2'd3
    } op_t;

    typedef struct packed {
        op_t          opcode;
        logic [31:0]  bound;
        logic [16:0]  coin_threshold;
    } in_item_t;

    typedef struct packed {
        logic [31:0]  value;
        logic         bad_bound;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIM,
        ST_CHECK,
        ST_DRAW,
        ST_DIV_VAL,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        LCG_IDLE,
        LCG_LO,
        LCG_HI_A,
        LCG_HI_B,
        LCG_SUM
    } lcg_phase_t;

    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  dividend;
        logic [WORD_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic  accept;
        logic  draw;
        logic  save_word;
        logic  set_pending;
        logic  clr_pending;
        logic  lim_load;
        logic  res_load;
        logic  out_load;
    } ctrl_t;

    // XSH-RR output permutation of the old LCG state.
    function automatic logic [31:0] pcg_output(input logic [63:0] s);
        logic [63:0] mixed;
        logic [31:0] x;
        logic [63:0] rot;
        mixed = (s >> 18) ^ s;
        x = mixed[58:27];
        rot = {x, x} >> s[63:59];
        return rot[31:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pcg_lcg.sv
// 64-bit LCG state register with a shared 32x32 multiplier; each step runs LO, HI_A, HI_B, SUM.
// Depends on pcg_pkg.
`default_nettype none

module pcg_lcg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         seed_we,
    input  wire logic [63:0]  seed,
    input  wire logic         advance,
    output logic              busy,
    output logic [63:0]       lcg_state
);

    pcg_pkg::lcg_phase_t phase_reg, phase_next;
    logic [63:0] lcg_state_reg, lcg_state_next;
    logic [63:0] opnd_reg;
    logic [63:0] p0_reg;
    logic [31:0] cross_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] product;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            pcg_pkg::LCG_IDLE:
            begin
                if (advance)
                begin
                    phase_next = pcg_pkg::LCG_LO;
                end
            end
            pcg_pkg::LCG_LO:   phase_next = pcg_pkg::LCG_HI_A;
            pcg_pkg::LCG_HI_A: phase_next = pcg_pkg::LCG_HI_B;
            pcg_pkg::LCG_HI_B: phase_next = pcg_pkg::LCG_SUM;
            pcg_pkg::LCG_SUM:  phase_next = pcg_pkg::LCG_IDLE;
            default:           phase_next = pcg_pkg::LCG_IDLE;
        endcase
        // A seed write starts a fresh step at once, even while one is running.
        if (seed_we)
        begin
            phase_next = pcg_pkg::LCG_LO;
        end
    end

    always_comb
    begin
        mul_a = opnd_reg[31:0];
        mul_b = pcg_pkg::PCG_MULT[31:0];
        lcg_state_next = lcg_state_reg;
        case (phase_reg)
            pcg_pkg::LCG_HI_A:
            begin
                mul_a = opnd_reg[63:32];
            end
            pcg_pkg::LCG_HI_B:
            begin
                mul_b = pcg_pkg::PCG_MULT[63:32];
            end
            pcg_pkg::LCG_SUM:
            begin
                lcg_state_next = p0_reg + {cross_reg, 32'd0} + pcg_pkg::PCG_INC;
            end
            default:
            begin
                mul_a = opnd_reg[31:0];
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pcg_pkg::LCG_IDLE;
            lcg_state_reg <= pcg_pkg::PCG_RESET_STATE;
        end
        else
        begin
            phase_reg <= phase_next;
            lcg_state_reg <= lcg_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seed_we)
        begin
            opnd_reg <= seed + pcg_pkg::PCG_INC;
        end
        else if (phase_reg == pcg_pkg::LCG_IDLE && advance)
        begin
            opnd_reg <= lcg_state_reg;
        end
        case (phase_reg)
            pcg_pkg::LCG_LO:   p0_reg <= product;
            pcg_pkg::LCG_HI_A: cross_reg <= product[31:0];
            pcg_pkg::LCG_HI_B: cross_reg <= cross_reg + product[31:0];
            default:
            begin
                cross_reg <= cross_reg;
            end
        endcase
    end

    assign busy = (phase_reg != pcg_pkg::LCG_IDLE);
    assign lcg_state = lcg_state_reg;

endmodule

`default_nettype wire

>>> rtl/pcg_div.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on pcg_pkg.
`default_nettype none

module pcg_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pcg_pkg::div_req_t           req,
    output logic                             busy,
    output logic [pcg_pkg::WORD_W-1:0]       remainder
);

    logic                          active_reg;
    logic [pcg_pkg::CNT_W-1:0]     count_reg;
    logic [pcg_pkg::WORD_W-1:0]    quo_reg;
    logic [pcg_pkg::WORD_W-1:0]    rem_reg, rem_next;
    logic [pcg_pkg::WORD_W-1:0]    dsr_reg;
    logic [pcg_pkg::WORD_W:0]      trial;
    logic [pcg_pkg::WORD_W:0]      diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[pcg_pkg::WORD_W-1]};
        diff = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[pcg_pkg::WORD_W-1:0];
        end
        else
        begin
            rem_next = trial[pcg_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            active_reg <= 1'b1;
            count_reg <= '0;
        end
        else if (active_reg)
        begin
            count_reg <= count_reg + pcg_pkg::CNT_W'(1);
            if (count_reg == pcg_pkg::CNT_W'(pcg_pkg::WORD_W - 1))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            quo_reg <= {quo_reg[pcg_pkg::WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy = active_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/pcg32_random_source.sv
// PCG32 XSH-RR random source: request sequencer, result register and checks.
// Depends on pcg_pkg, pcg_lcg, pcg_div and pcg32_random_source_assert.svh.
//
// Requests arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a transfer happens when valid is high and
// stall is low. Each request gives exactly one result. The user must write
// the seed through cfg_we/cfg_data while the block is idle; it has no guard.
// Raw words, halves and coin bits pass through the result and output registers.
// A request that draws a word keeps in_stall high while the LCG step runs on
// the shared 32x32 multiplier, so the next request is taken only once that
// step has ended.
// A bounded request runs two passes of the serial remainder unit, one for the
// rejection limit and one for the result, and an LCG step and check for each
// rejected word.
// A zero bound returns at once with bad_bound set and draws nothing.
// A seed write occupies the multiplier for a whole LCG step, during which no
// request is taken.
// After reset the state already holds the seed-zero value, no half is saved,
// and the block is ready. A stalled result is held in the output register;
// one more request is taken meanwhile and waits for the register to free.
`default_nettype none
`include "pcg32_random_source_assert.svh"

module pcg32_random_source (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [63:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pcg_pkg::in_item_t    in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pcg_pkg::out_item_t        out_data
);

    pcg_pkg::state_t     state_reg, state_next;
    pcg_pkg::ctrl_t      ctrl;
    pcg_pkg::div_req_t   div_req;
    pcg_pkg::out_item_t  out_data_reg;

    logic          lcg_busy;
    logic [63:0]   lcg_state;
    logic          div_busy;
    logic [31:0]   div_rem;
    logic [31:0]   cur_word;
    logic [31:0]   bound_reg;
    logic [31:0]   word_reg;
    logic [31:0]   lim_reg;
    logic [31:0]   saved_reg;
    logic          pending_reg;
    logic [31:0]   res_value_reg, res_value_next;
    logic          res_bad_reg, res_bad_next;
    logic          out_valid_reg;
    logic [15:0]   half;
    logic          out_free;

    pcg_lcg u_lcg (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (cfg_we),
        .seed      (cfg_data),
        .advance   (ctrl.draw),
        .busy      (lcg_busy),
        .lcg_state (lcg_state)
    );

    pcg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    assign cur_word = pcg_pkg::pcg_output(lcg_state);
    assign half = pending_reg ? saved_reg[31:16] : cur_word[15:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != pcg_pkg::ST_IDLE) || lcg_busy || cfg_we;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcg_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (in_data.opcode == pcg_pkg::OP_BOUNDED && in_data.bound != '0)
                    begin
                        state_next = pcg_pkg::ST_LIM;
                    end
                    else
                    begin
                        state_next = pcg_pkg::ST_FINISH;
                    end
                end
            end
            pcg_pkg::ST_LIM:
            begin
                if (!div_busy && !lcg_busy)
                begin
                    state_next = pcg_pkg::ST_CHECK;
                end
            end
            pcg_pkg::ST_CHECK:
            begin
                if (word_reg < lim_reg)
                begin
                    state_next = pcg_pkg::ST_DRAW;
                end
                else
                begin
                    state_next = pcg_pkg::ST_DIV_VAL;
                end
            end
            pcg_pkg::ST_DRAW:
            begin
                if (!lcg_busy)
                begin
                    state_next = pcg_pkg::ST_CHECK;
                end
            end
            pcg_pkg::ST_DIV_VAL:
            begin
                if (!div_busy)
                begin
                    state_next = pcg_pkg::ST_FINISH;
                end
            end
            pcg_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pcg_pkg::ST_IDLE;
                end
            end
            default: state_next = pcg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        div_req.start = 1'b0;
        div_req.dividend = word_reg;
        div_req.divisor = bound_reg;
        res_value_next = res_value_reg;
        res_bad_next = 1'b0;
        case (state_reg)
            pcg_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    ctrl.accept = 1'b1;
                    ctrl.res_load = 1'b1;
                    case (in_data.opcode)
                        pcg_pkg::OP_RAW:
                        begin
                            ctrl.draw = 1'b1;
                            res_value_next = cur_word;
                        end
                        pcg_pkg::OP_BOUNDED:
                        begin
                            if (in_data.bound == '0)
                            begin
                                res_value_next = '0;
                                res_bad_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.draw = 1'b1;
                                ctrl.res_load = 1'b0;
                                div_req.start = 1'b1;
                                div_req.dividend = 32'd0 - in_data.bound;
                                div_req.divisor = in_data.bound;
                            end
                        end
                        default:
                        begin
                            if (pending_reg)
                            begin
                                ctrl.clr_pending = 1'b1;
                            end
                            else
                            begin
                                ctrl.draw = 1'b1;
                                ctrl.save_word = 1'b1;
                                ctrl.set_pending = 1'b1;
                            end
                            if (in_data.opcode == pcg_pkg::OP_HALF)
                            begin
                                res_value_next = {16'd0, half};
                            end
                            else
                            begin
                                res_value_next = {31'd0, ({1'b0, half} < in_data.coin_threshold)};
                            end
                        end
                    endcase
                end
            end
            pcg_pkg::ST_LIM:
            begin
                ctrl.lim_load = !div_busy && !lcg_busy;
            end
            pcg_pkg::ST_CHECK:
            begin
                if (word_reg < lim_reg)
                begin
                    ctrl.draw = 1'b1;
                end
                else
                begin
                    div_req.start = 1'b1;
                end
            end
            pcg_pkg::ST_DIV_VAL:
            begin
                if (!div_busy)
                begin
                    ctrl.res_load = 1'b1;
                    res_value_next = div_rem;
                end
            end
            pcg_pkg::ST_FINISH:
            begin
                ctrl.out_load = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcg_pkg::ST_IDLE;
            saved_reg <= '0;
            pending_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.save_word)
            begin
                saved_reg <= cur_word;
            end
            if (ctrl.set_pending)
            begin
                pending_reg <= 1'b1;
            end
            else if (ctrl.clr_pending)
            begin
                pending_reg <= 1'b0;
            end
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            bound_reg <= in_data.bound;
        end
        if (ctrl.draw)
        begin
            word_reg <= cur_word;
        end
        if (ctrl.lim_load)
        begin
            lim_reg <= div_rem;
        end
        if (ctrl.res_load)
        begin
            res_value_reg <= res_value_next;
            res_bad_reg <= res_bad_next;
        end
        if (ctrl.out_load)
        begin
            out_data_reg.value <= res_value_reg;
            out_data_reg.bad_bound <= res_bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    `PCG_ASSERT(a_div_start_idle, div_req.start |-> !div_busy, "divider restarted while busy")
    `PCG_ASSERT(a_check_lcg_idle, state_reg == pcg_pkg::ST_CHECK |-> !lcg_busy, "word check before LCG step ended")
    `PCG_ASSERT(a_pending_from_idle, !$stable(pending_reg) |-> $past(state_reg) == pcg_pkg::ST_IDLE, "half state changed outside a request transfer")
    `PCG_ASSERT_ALWAYS(a_bad_bound_zero, out_valid && out_data.bad_bound |-> out_data.value == '0, "flagged bound with nonzero value")

endmodule

`default_nettype wire
